### src/lc3isc_pkg.sv
// Shared types, codes and helpers for the LC-3 instruction step core.
package lc3isc_pkg;

    localparam logic [1:0] OP_MEM_WRITE = 2'd0;
    localparam logic [1:0] OP_REG_WRITE = 2'd1;
    localparam logic [1:0] OP_EXECUTE   = 2'd2;
    localparam logic [1:0] OP_RESUME    = 2'd3;

    localparam logic [2:0] STAT_OK     = 3'd0;
    localparam logic [2:0] STAT_NOTRUN = 3'd1;
    localparam logic [2:0] STAT_ACV    = 3'd2;
    localparam logic [2:0] STAT_ILL    = 3'd3;
    localparam logic [2:0] STAT_PMV    = 3'd4;
    localparam logic [2:0] STAT_HALT   = 3'd5;

    localparam logic [3:0] OPC_BR   = 4'd0;
    localparam logic [3:0] OPC_ADD  = 4'd1;
    localparam logic [3:0] OPC_LD   = 4'd2;
    localparam logic [3:0] OPC_ST   = 4'd3;
    localparam logic [3:0] OPC_JSR  = 4'd4;
    localparam logic [3:0] OPC_AND  = 4'd5;
    localparam logic [3:0] OPC_LDR  = 4'd6;
    localparam logic [3:0] OPC_STR  = 4'd7;
    localparam logic [3:0] OPC_RTI  = 4'd8;
    localparam logic [3:0] OPC_NOT  = 4'd9;
    localparam logic [3:0] OPC_LDI  = 4'd10;
    localparam logic [3:0] OPC_STI  = 4'd11;
    localparam logic [3:0] OPC_JMP  = 4'd12;
    localparam logic [3:0] OPC_LEA  = 4'd14;
    localparam logic [3:0] OPC_TRAP = 4'd15;

    localparam logic [3:0] RIDX_PC  = 4'd8;
    localparam logic [3:0] RIDX_IR  = 4'd9;
    localparam logic [3:0] RIDX_PSR = 4'd10;
    localparam logic [3:0] RIDX_USP = 4'd11;
    localparam logic [3:0] RIDX_SSP = 4'd12;

    localparam logic [15:0] PC_RESET  = 16'h3000;
    localparam logic [15:0] PSR_RESET = 16'h8002;
    localparam logic [15:0] USER_LOW  = 16'h3000;
    localparam logic [15:0] USER_HIGH = 16'hFDFF;
    localparam logic [15:0] MCR_ADDR  = 16'hFFFE;
    localparam logic [15:0] MCR_RUN   = 16'h8000;
    localparam logic [15:0] MCR_STOP  = 16'h7FFF;
    localparam logic [15:0] CC_CLEAR  = 16'hFFF8;
    localparam logic [7:0]  VEC_HALT_LO = 8'h20;
    localparam logic [7:0]  VEC_HALT_HI = 8'h25;

    typedef struct packed {
        logic        en;
        logic        we;
        logic [15:0] addr;
        logic [15:0] wdata;
    } mem_req_t;

    function automatic logic may_access(input logic [15:0] psr, input logic [15:0] addr);
        return !psr[15] || (addr >= USER_LOW && addr <= USER_HIGH);
    endfunction

    function automatic logic [15:0] with_cc(input logic [15:0] psr, input logic [15:0] v);
        logic [2:0] cc;
        if (v[15]) cc = 3'b100;
        else if (v == 16'h0000) cc = 3'b010;
        else cc = 3'b001;
        return (psr & CC_CLEAR) | {13'd0, cc};
    endfunction

endpackage

### src/lc3isc_mem.sv
// Single-port main memory with registered read and a clearing sweep after reset.
module lc3isc_mem #(
    parameter int Depth = 65536
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lc3isc_pkg::mem_req_t req,
    output logic [15:0]          rdata,
    output logic                 busy
);
    localparam int AW = $clog2(Depth);

    logic [15:0]   mem [Depth];
    logic [AW-1:0] clr_reg;
    logic          busy_reg;

    assign busy = busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg  <= '0;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            clr_reg <= clr_reg + 1'b1;
            if (clr_reg == AW'(Depth - 1)) busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[clr_reg] <= 16'h0000;
        end else if (req.en && req.we) begin
            mem[req.addr[AW-1:0]] <= req.wdata;
        end
        if (req.en && !req.we) rdata <= mem[req.addr[AW-1:0]];
    end
endmodule

### src/lc3_instruction_step_core.sv
// LC-3 instruction step core: request decoder, instruction sequencer and register file.
// Each request yields one result, registered once S_DONE finds the output register free.
// Memory and register writes, resume and refused execute requests go from acceptance
// straight to S_DONE; an instruction passes S_FETCH and S_EXEC (register ops, LEA, BR,
// JMP, JSR, ST, STR and any instruction that faults at decode end there), and LD, LDR,
// STI, LDI, RTI and TRAP add further states, set by the single memory port: fetch, then
// one access per cycle for indirection, stack pushes and pops and the vector or MCR read.
// A new request is taken while the last result still waits on m_ready. After reset the
// memory is cleared one word a cycle, and s_ready stays low while it is cleared.
module lc3_instruction_step_core #(
    parameter int MEMORY_WORDS = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_address,
    input  logic [15:0] s_value,
    input  logic [3:0]  s_reg_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_pc_out,
    output logic [15:0] m_ir_out,
    output logic [15:0] m_psr_out
);
    typedef enum logic [3:0] {
        S_IDLE, S_FETCH, S_EXEC, S_LD1, S_LD2, S_STI, S_TPUSH, S_TVEC, S_TLOAD,
        S_RTI1, S_RTI2, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [15:0] regs_reg [8];
    logic [15:0] regs_next [8];
    logic [15:0] pc_reg, pc_next, ir_reg, ir_next, psr_reg, psr_next;
    logic [15:0] usp_reg, usp_next, ssp_reg, ssp_next;
    logic        run_reg, run_next, halted_reg, halted_next;
    logic [2:0]  st_reg, st_next;
    logic        m_valid_reg, m_valid_next;
    logic [2:0]  m_status_reg, m_status_next;
    logic [15:0] m_pc_reg, m_pc_next, m_ir_reg, m_ir_next, m_psr_reg, m_psr_next;

    lc3isc_pkg::mem_req_t mem_req;
    logic [15:0] mem_rdata;
    logic        mem_busy;

    logic [3:0]  opc;
    logic [2:0]  dr, sr1;
    logic [15:0] pc_off9, pc_off11, base_off6, alu_b, alu_res, sp_base, tgt;
    logic        vec_halt;

    lc3isc_mem #(.Depth(MEMORY_WORDS)) u_mem (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (mem_req),
        .rdata  (mem_rdata),
        .busy   (mem_busy)
    );

    assign s_ready   = (state_reg == S_IDLE) && !mem_busy;
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_pc_out  = m_pc_reg;
    assign m_ir_out  = m_ir_reg;
    assign m_psr_out = m_psr_reg;

    assign opc       = ir_reg[15:12];
    assign dr        = ir_reg[11:9];
    assign sr1       = ir_reg[8:6];
    assign pc_off9   = pc_reg + {{7{ir_reg[8]}}, ir_reg[8:0]};
    assign pc_off11  = pc_reg + {{5{ir_reg[10]}}, ir_reg[10:0]};
    assign base_off6 = regs_reg[sr1] + {{10{ir_reg[5]}}, ir_reg[5:0]};
    assign alu_b     = ir_reg[5] ? {{11{ir_reg[4]}}, ir_reg[4:0]} : regs_reg[ir_reg[2:0]];
    assign sp_base   = psr_reg[15] ? ssp_reg : regs_reg[6];
    assign vec_halt  = ir_reg[7:0] >= lc3isc_pkg::VEC_HALT_LO
                    && ir_reg[7:0] <= lc3isc_pkg::VEC_HALT_HI;

    always_comb begin
        unique case (opc)
            lc3isc_pkg::OPC_ADD: alu_res = regs_reg[sr1] + alu_b;
            lc3isc_pkg::OPC_AND: alu_res = regs_reg[sr1] & alu_b;
            default:             alu_res = ~regs_reg[sr1];
        endcase
        unique case (opc)
            lc3isc_pkg::OPC_BR:  tgt = pc_off9;
            lc3isc_pkg::OPC_JSR: tgt = ir_reg[11] ? pc_off11 : regs_reg[sr1];
            default:             tgt = regs_reg[sr1];
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        regs_next   = regs_reg;
        pc_next     = pc_reg;
        ir_next     = ir_reg;
        psr_next    = psr_reg;
        usp_next    = usp_reg;
        ssp_next    = ssp_reg;
        run_next    = run_reg;
        halted_next = halted_reg;
        st_next     = st_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_pc_next     = m_pc_reg;
        m_ir_next     = m_ir_reg;
        m_psr_next    = m_psr_reg;
        mem_req     = '0;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    st_next    = lc3isc_pkg::STAT_OK;
                    state_next = S_DONE;
                    unique case (s_operation)
                        lc3isc_pkg::OP_MEM_WRITE: begin
                            mem_req = '{en: 1'b1, we: 1'b1, addr: s_address, wdata: s_value};
                        end
                        lc3isc_pkg::OP_REG_WRITE: begin
                            case (s_reg_index)
                                lc3isc_pkg::RIDX_PC:  pc_next  = s_value;
                                lc3isc_pkg::RIDX_IR:  ir_next  = s_value;
                                lc3isc_pkg::RIDX_PSR: psr_next = s_value;
                                lc3isc_pkg::RIDX_USP: usp_next = s_value;
                                lc3isc_pkg::RIDX_SSP: ssp_next = s_value;
                                default: begin
                                    if (!s_reg_index[3]) regs_next[s_reg_index[2:0]] = s_value;
                                end
                            endcase
                        end
                        lc3isc_pkg::OP_EXECUTE: begin
                            if (!run_reg) begin
                                st_next = lc3isc_pkg::STAT_NOTRUN;
                            end else if (!lc3isc_pkg::may_access(psr_reg, pc_reg)) begin
                                st_next  = lc3isc_pkg::STAT_ACV;
                                run_next = 1'b0;
                            end else begin
                                mem_req    = '{en: 1'b1, we: 1'b0, addr: pc_reg, wdata: 16'h0};
                                state_next = S_FETCH;
                            end
                        end
                        default: begin
                            run_next = 1'b1;
                            if (halted_reg) begin
                                mem_req = '{en: 1'b1, we: 1'b1, addr: lc3isc_pkg::MCR_ADDR,
                                            wdata: lc3isc_pkg::MCR_RUN};
                                halted_next = 1'b0;
                            end
                        end
                    endcase
                end
            end
            S_FETCH: begin
                ir_next    = mem_rdata;
                pc_next    = pc_reg + 16'd1;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_DONE;
                case (opc)
                    lc3isc_pkg::OPC_ADD, lc3isc_pkg::OPC_AND, lc3isc_pkg::OPC_NOT: begin
                        regs_next[dr] = alu_res;
                        psr_next      = lc3isc_pkg::with_cc(psr_reg, alu_res);
                    end
                    lc3isc_pkg::OPC_LD, lc3isc_pkg::OPC_LDI, lc3isc_pkg::OPC_LDR,
                    lc3isc_pkg::OPC_ST, lc3isc_pkg::OPC_STI, lc3isc_pkg::OPC_STR: begin
                        logic [15:0] ea;
                        ea = (opc == lc3isc_pkg::OPC_LDR || opc == lc3isc_pkg::OPC_STR)
                             ? base_off6 : pc_off9;
                        if (!lc3isc_pkg::may_access(psr_reg, ea)) begin
                            st_next  = lc3isc_pkg::STAT_ACV;
                            run_next = 1'b0;
                        end else if (opc == lc3isc_pkg::OPC_ST || opc == lc3isc_pkg::OPC_STR) begin
                            mem_req = '{en: 1'b1, we: 1'b1, addr: ea, wdata: regs_reg[dr]};
                        end else begin
                            mem_req    = '{en: 1'b1, we: 1'b0, addr: ea, wdata: 16'h0};
                            state_next = (opc == lc3isc_pkg::OPC_STI) ? S_STI : S_LD1;
                        end
                    end
                    lc3isc_pkg::OPC_LEA: regs_next[dr] = pc_off9;
                    lc3isc_pkg::OPC_BR, lc3isc_pkg::OPC_JMP, lc3isc_pkg::OPC_JSR: begin
                        if (opc == lc3isc_pkg::OPC_JSR) regs_next[7] = pc_reg;
                        if (opc != lc3isc_pkg::OPC_BR || (dr & psr_reg[2:0]) != 3'b000) begin
                            if (lc3isc_pkg::may_access(psr_reg, tgt)) begin
                                pc_next = tgt;
                            end else begin
                                st_next  = lc3isc_pkg::STAT_ACV;
                                run_next = 1'b0;
                            end
                        end
                    end
                    lc3isc_pkg::OPC_TRAP: begin
                        if (psr_reg[15]) usp_next = regs_reg[6];
                        psr_next     = psr_reg & lc3isc_pkg::MCR_STOP;
                        regs_next[6] = sp_base - 16'd1;
                        mem_req = '{en: 1'b1, we: 1'b1, addr: sp_base - 16'd1, wdata: psr_reg};
                        state_next = S_TPUSH;
                    end
                    lc3isc_pkg::OPC_RTI: begin
                        if (psr_reg[15]) begin
                            st_next  = lc3isc_pkg::STAT_PMV;
                            run_next = 1'b0;
                        end else begin
                            mem_req = '{en: 1'b1, we: 1'b0, addr: regs_reg[6], wdata: 16'h0};
                            state_next = S_RTI1;
                        end
                    end
                    default: begin
                        st_next  = lc3isc_pkg::STAT_ILL;
                        run_next = 1'b0;
                    end
                endcase
            end
            S_LD1: begin
                state_next = S_DONE;
                if (opc == lc3isc_pkg::OPC_LDI) begin
                    if (!lc3isc_pkg::may_access(psr_reg, mem_rdata)) begin
                        st_next  = lc3isc_pkg::STAT_ACV;
                        run_next = 1'b0;
                    end else begin
                        mem_req    = '{en: 1'b1, we: 1'b0, addr: mem_rdata, wdata: 16'h0};
                        state_next = S_LD2;
                    end
                end else begin
                    regs_next[dr] = mem_rdata;
                    psr_next      = lc3isc_pkg::with_cc(psr_reg, mem_rdata);
                end
            end
            S_LD2: begin
                regs_next[dr] = mem_rdata;
                psr_next      = lc3isc_pkg::with_cc(psr_reg, mem_rdata);
                state_next    = S_DONE;
            end
            S_STI: begin
                state_next = S_DONE;
                if (!lc3isc_pkg::may_access(psr_reg, mem_rdata)) begin
                    st_next  = lc3isc_pkg::STAT_ACV;
                    run_next = 1'b0;
                end else begin
                    mem_req = '{en: 1'b1, we: 1'b1, addr: mem_rdata, wdata: regs_reg[dr]};
                end
            end
            S_TPUSH: begin
                regs_next[6] = regs_reg[6] - 16'd1;
                mem_req = '{en: 1'b1, we: 1'b1, addr: regs_reg[6] - 16'd1, wdata: pc_reg};
                state_next = S_TVEC;
            end
            S_TVEC: begin
                mem_req = '{en: 1'b1, we: 1'b0,
                            addr: vec_halt ? lc3isc_pkg::MCR_ADDR : {8'h00, ir_reg[7:0]},
                            wdata: 16'h0};
                state_next = S_TLOAD;
            end
            S_TLOAD: begin
                state_next = S_DONE;
                if (vec_halt) begin
                    mem_req = '{en: 1'b1, we: 1'b1, addr: lc3isc_pkg::MCR_ADDR,
                                wdata: mem_rdata & lc3isc_pkg::MCR_STOP};
                    run_next    = 1'b0;
                    halted_next = 1'b1;
                    st_next     = lc3isc_pkg::STAT_HALT;
                end else begin
                    pc_next = mem_rdata;
                end
            end
            S_RTI1: begin
                pc_next      = mem_rdata;
                regs_next[6] = regs_reg[6] + 16'd1;
                mem_req = '{en: 1'b1, we: 1'b0, addr: regs_reg[6] + 16'd1, wdata: 16'h0};
                state_next = S_RTI2;
            end
            S_RTI2: begin
                psr_next = mem_rdata;
                if (mem_rdata[15]) begin
                    ssp_next     = regs_reg[6] + 16'd1;
                    regs_next[6] = usp_reg;
                end else begin
                    regs_next[6] = regs_reg[6] + 16'd1;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = st_reg;
                    m_pc_next     = pc_reg;
                    m_ir_next     = ir_reg;
                    m_psr_next    = psr_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            regs_reg    <= '{default: 16'h0000};
            pc_reg      <= lc3isc_pkg::PC_RESET;
            ir_reg      <= 16'h0000;
            psr_reg     <= lc3isc_pkg::PSR_RESET;
            usp_reg     <= 16'h0000;
            ssp_reg     <= 16'h0000;
            run_reg     <= 1'b0;
            halted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            regs_reg    <= regs_next;
            pc_reg      <= pc_next;
            ir_reg      <= ir_next;
            psr_reg     <= psr_next;
            usp_reg     <= usp_next;
            ssp_reg     <= ssp_next;
            run_reg     <= run_next;
            halted_reg  <= halted_next;
            m_valid_reg <= m_valid_next;
        end
        st_reg       <= st_next;
        m_status_reg <= m_status_next;
        m_pc_reg     <= m_pc_next;
        m_ir_reg     <= m_ir_next;
        m_psr_reg    <= m_psr_next;
    end

    a_no_req_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_busy |-> !s_ready)
        else $error("request taken during memory clear");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in flight");

    a_halt_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> !run_reg)
        else $error("core halted yet running");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_status_reg <= lc3isc_pkg::STAT_HALT)
        else $error("undefined status code");
endmodule
